[hw/rtl/voxel_surface_cull_defines.svh]
// Assertion macros used by the voxel surface cull back end.
`ifndef VOXEL_SURFACE_CULL_DEFINES_SVH
`define VOXEL_SURFACE_CULL_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define VSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define VSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/vsc_pkg.sv]
// Shared types and constants for the voxel surface cull block.
package vsc_pkg;

  // item kinds carried on in_tuser
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_TEST  = 1'b1;

  // configuration register indexes
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 21;
  localparam logic [CFG_AW-1:0] CFG_CHUNK_X = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_CHUNK_Y = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_CHUNK_Z = 2'd2;

  localparam int LW = 5;   // local coordinate width
  localparam int TW = 8;   // texture id width
  localparam int WW = 26;  // world coordinate width

  localparam int IN_DW  = 24;
  localparam int OUT_DW = 88;

  // queue geometry
  localparam int QDEPTH = 2;
  localparam int QPW    = 1;
  localparam int QCW    = 2;

  typedef struct packed {
    logic                 action;
    logic [LW-1:0]        lx;
    logic [LW-1:0]        ly;
    logic [LW-1:0]        lz;
    logic                 vact;
    logic [TW-1:0]        vtex;
    logic                 in_chunk;
    logic                 x_lo;
    logic                 x_hi;
    logic                 y_lo;
    logic                 y_hi;
    logic                 z_lo;
    logic                 z_hi;
    logic signed [WW-1:0] wx;
    logic signed [WW-1:0] wy;
    logic signed [WW-1:0] wz;
  } vsc_item_t;

  // visible sits in the lowest bit
  typedef struct packed {
    logic [TW-1:0]        texture_out;
    logic signed [WW-1:0] world_z;
    logic signed [WW-1:0] world_y;
    logic signed [WW-1:0] world_x;
    logic                 visible;
  } vsc_res_t;

  localparam int RES_W = $bits(vsc_res_t);
  localparam int PADW  = OUT_DW - RES_W;

endpackage

[hw/rtl/vsc_queue.sv]
// Two-entry FIFO that decouples neighboring stages.
module vsc_queue import vsc_pkg::*; #(
  parameter int W = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  logic [W-1:0]   din,
  input  logic           pop,
  output logic [W-1:0]   dout,
  output logic [QCW-1:0] count,
  output logic           full,
  output logic           empty
);

  logic [W-1:0]   slot_r [QDEPTH];
  logic [QPW-1:0] wp_r;
  logic [QPW-1:0] rp_r;
  logic [QCW-1:0] cnt_r;
  logic           do_push;
  logic           do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == QCW'(QDEPTH));
  assign do_pop  = pop & ~empty;
  assign do_push = push & ~full;
  assign dout    = slot_r[rp_r];
  assign count   = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + QCW'(do_push) - QCW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= din;
    end
  end

endmodule

[hw/rtl/vsc_front.sv]
// Front end: takes requests, holds chunk position, classifies coordinates.
module vsc_front import vsc_pkg::*; #(
  parameter int CHUNK_EDGE = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,
  input  logic              in_tuser,
  input  logic              q_full,
  input  logic              clr_busy,
  output logic              push,
  output vsc_item_t         item
);

  localparam logic [6:0]        EDGE_LIM = 7'(CHUNK_EDGE);
  localparam logic [6:0]        EDGE_TOP = 7'(CHUNK_EDGE - 1);
  localparam logic signed [7:0] EDGE_S   = 8'(CHUNK_EDGE);

  logic signed [CFG_DW-1:0] chunk_x_r;
  logic signed [CFG_DW-1:0] chunk_y_r;
  logic signed [CFG_DW-1:0] chunk_z_r;
  logic [LW-1:0]            lx;
  logic [LW-1:0]            ly;
  logic [LW-1:0]            lz;
  logic [6:0]               ex;
  logic [6:0]               ey;
  logic [6:0]               ez;

  function automatic logic signed [WW-1:0] world_of(input logic signed [CFG_DW-1:0] c,
                                                     input logic [LW-1:0] l);
    logic signed [28:0] p;
    p = c * EDGE_S;
    return WW'(p + 29'(l));
  endfunction

  assign lx = in_tdata[4:0];
  assign ly = in_tdata[9:5];
  assign lz = in_tdata[14:10];
  assign ex = 7'(lx);
  assign ey = 7'(ly);
  assign ez = 7'(lz);

  // hold off while the store sweep runs or the queue has no room
  assign in_tready = ~clr_busy & ~q_full;
  assign push      = in_tvalid & in_tready;

  always_comb begin
    item          = '0;
    item.action   = in_tuser;
    item.lx       = lx;
    item.ly       = ly;
    item.lz       = lz;
    item.vact     = in_tdata[15];
    item.vtex     = in_tdata[23:16];
    item.in_chunk = (ex < EDGE_LIM) && (ey < EDGE_LIM) && (ez < EDGE_LIM);
    item.x_lo     = (lx == '0);
    item.x_hi     = (ex >= EDGE_TOP);
    item.y_lo     = (ly == '0);
    item.y_hi     = (ey >= EDGE_TOP);
    item.z_lo     = (lz == '0);
    item.z_hi     = (ez >= EDGE_TOP);
    item.wx       = world_of(chunk_x_r, lx);
    item.wy       = world_of(chunk_y_r, ly);
    item.wz       = world_of(chunk_z_r, lz);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_x_r <= '0;
      chunk_y_r <= '0;
      chunk_z_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_CHUNK_X: chunk_x_r <= cfg_wdata;
        CFG_CHUNK_Y: chunk_y_r <= cfg_wdata;
        CFG_CHUNK_Z: chunk_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/vsc_back.sv]
// Back end: voxel store, neighbor reads and visibility result.
`include "voxel_surface_cull_defines.svh"
module vsc_back import vsc_pkg::*; #(
  parameter int CHUNK_EDGE = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  vsc_item_t         q_item,
  output logic              q_pop,
  output logic              clr_busy,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata
);

  localparam int CW   = $clog2(CHUNK_EDGE);
  localparam int ROWN = 1 << CW;
  localparam int RAW  = 2 * CW;
  localparam int ROWS = 1 << RAW;
  localparam int EW   = TW + 1;

  // rows keyed by (x,y); each row holds every z entry
  logic [ROWN*EW-1:0] vox_mem [ROWS];
  logic [ROWN-1:0]    act_mem [ROWS];

  logic               clr_r;
  logic [RAW-1:0]     clr_row_r;
  logic               s1_vld_r;
  logic               s2_vld_r;
  vsc_item_t          e1_r;
  vsc_item_t          e2_r;
  logic [ROWN*EW-1:0] ctr_r;
  logic [ROWN-1:0]    nb0_r;
  logic [ROWN-1:0]    nb1_r;
  logic               part_r;
  logic               part_nxt;
  logic               cact_r;
  logic [TW-1:0]      ctex_r;

  logic [CW-1:0]      hx;
  logic [CW-1:0]      hy;
  logic [CW-1:0]      hz;
  logic [CW-1:0]      x1;
  logic [CW-1:0]      y1;
  logic [CW-1:0]      z1;
  logic [CW-1:0]      z1m;
  logic [CW-1:0]      z1p;
  logic [CW-1:0]      z2;
  logic [RAW-1:0]     rd_a;
  logic [RAW-1:0]     rd_b;
  logic [RAW-1:0]     rd_c;
  logic               wr_en;
  logic [EW-1:0]      cent;
  logic               exp_ym;
  logic               exp_yp;
  logic               hit;
  vsc_res_t           res_d;

  logic               oq_pop;
  logic [RES_W-1:0]   oq_dout;
  logic [QCW-1:0]     oq_cnt;
  logic               oq_full;
  logic               oq_empty;

  assign clr_busy = clr_r;

  assign hx = CW'(q_item.lx);
  assign hy = CW'(q_item.ly);
  assign hz = CW'(q_item.lz);
  assign x1 = CW'(e1_r.lx);
  assign y1 = CW'(e1_r.ly);
  assign z1 = CW'(e1_r.lz);
  assign z2 = CW'(e2_r.lz);

  // take the next request only when the store sweep is done, the neighbor read ports are free and the result has room
  assign q_pop = ~clr_r & ~q_empty & ~s1_vld_r &
                 ((oq_cnt + QCW'(s2_vld_r)) < QCW'(QDEPTH));
  assign wr_en = q_pop & (q_item.action == ACT_WRITE) & q_item.in_chunk;

  // x neighbors are read as a request is taken, y neighbors while s1_vld_r is set
  assign rd_a = s1_vld_r ? {x1, CW'(y1 - 1'b1)} : {CW'(hx - 1'b1), hy};
  assign rd_b = s1_vld_r ? {x1, CW'(y1 + 1'b1)} : {CW'(hx + 1'b1), hy};
  assign rd_c = {hx, hy};

  always_ff @(posedge clk) begin
    if (clr_r) begin
      vox_mem[clr_row_r] <= '0;
      act_mem[clr_row_r] <= '0;
    end else if (wr_en) begin
      vox_mem[rd_c][EW*hz +: EW] <= {q_item.vact, q_item.vtex};
      act_mem[rd_c][hz]          <= q_item.vact;
    end
    ctr_r <= vox_mem[rd_c];
    nb0_r <= act_mem[rd_a];
    nb1_r <= act_mem[rd_b];
  end

  // with s1_vld_r set: center entry, x neighbors and z neighbors
  assign z1m  = z1 - 1'b1;
  assign z1p  = z1 + 1'b1;
  assign cent = ctr_r[EW*z1 +: EW];

  always_comb begin
    part_nxt = (e1_r.x_lo | ~nb0_r[z1]) |
               (e1_r.x_hi | ~nb1_r[z1]) |
               (e1_r.z_lo | ~ctr_r[EW*z1m + EW - 1]) |
               (e1_r.z_hi | ~ctr_r[EW*z1p + EW - 1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_row_r <= '0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
    end else begin
      if (clr_r) begin
        clr_row_r <= clr_row_r + 1'b1;
        if (&clr_row_r) begin
          clr_r <= 1'b0;
        end
      end
      s1_vld_r <= q_pop;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      e1_r <= q_item;
    end
    if (s1_vld_r) begin
      e2_r   <= e1_r;
      part_r <= part_nxt;
      cact_r <= cent[EW-1];
      ctex_r <= cent[TW-1:0];
    end
  end

  // with s2_vld_r set: y neighbors close the test
  assign exp_ym = e2_r.y_lo | ~nb0_r[z2];
  assign exp_yp = e2_r.y_hi | ~nb1_r[z2];
  assign hit    = (e2_r.action == ACT_TEST) & e2_r.in_chunk;

  always_comb begin
    res_d             = '0;
    res_d.visible     = hit & cact_r & (part_r | exp_ym | exp_yp);
    res_d.texture_out = hit ? ctex_r : '0;
    if (e2_r.action == ACT_TEST) begin
      res_d.world_x = e2_r.wx;
      res_d.world_y = e2_r.wy;
      res_d.world_z = e2_r.wz;
    end
  end

  vsc_queue #(.W(RES_W)) u_oq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (s2_vld_r),
    .din   (res_d),
    .pop   (oq_pop),
    .dout  (oq_dout),
    .count (oq_cnt),
    .full  (oq_full),
    .empty (oq_empty)
  );

  assign out_tvalid = ~oq_empty;
  assign oq_pop     = out_tvalid & out_tready;
  assign out_tdata  = {{PADW{1'b0}}, oq_dout};

  `VSC_ASSERT_IMP(a_no_pop_in_clear, clr_r, !q_pop, "request taken during store sweep")
  `VSC_ASSERT_IMP(a_no_pop_in_s1, s1_vld_r, !q_pop, "neighbor read ports double booked")
  `VSC_ASSERT_NXT(a_s1_to_s2, s1_vld_r, s2_vld_r, "request lost between read cycles")
  `VSC_ASSERT_IMP(a_result_room, s2_vld_r, !oq_full, "result pushed into full queue")

endmodule

[hw/rtl/voxel_surface_cull.sv]
// A request passes the input queue, the e1_r and e2_r registers and the result queue to out_tdata.
// The back end takes no new request while the last one reads its y neighbors; the 4 neighbor rows go through the
// two read ports of the active-bit row memory, two rows per cycle.
// Reset: chunk position clears to 0, then the store is swept one (x,y) row per cycle over all
// 2**(2*clog2(CHUNK_EDGE)) rows (1024 at 32), with in_tready held low meanwhile.
module voxel_surface_cull import vsc_pkg::*; #(
  parameter int CHUNK_EDGE = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // local_x, local_y, local_z, voxel_active, voxel_texture
  input  logic              in_tuser,   // action
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata   // visible, world_x, world_y, world_z, texture_out, pad
);

  logic              f_push;
  vsc_item_t         f_item;
  logic [$bits(vsc_item_t)-1:0] iq_dout;
  logic              iq_full;
  logic              iq_empty;
  logic              b_pop;
  logic              clr_busy;

  vsc_front #(.CHUNK_EDGE(CHUNK_EDGE)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (iq_full),
    .clr_busy  (clr_busy),
    .push      (f_push),
    .item      (f_item)
  );

  vsc_queue #(.W($bits(vsc_item_t))) u_iq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .din   (f_item),
    .pop   (b_pop),
    .dout  (iq_dout),
    .count (),
    .full  (iq_full),
    .empty (iq_empty)
  );

  vsc_back #(.CHUNK_EDGE(CHUNK_EDGE)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (iq_empty),
    .q_item     (vsc_item_t'(iq_dout)),
    .q_pop      (b_pop),
    .clr_busy   (clr_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
